// ===== design/fswl_pkg.sv =====
package fswl_pkg;

   localparam int unsigned WORDS_PER_PAGE_DEF = 1024;
   localparam int unsigned WORD_W             = 32;
   localparam int unsigned POS_W              = 10;
   localparam logic [WORD_W-1:0] ERASED_WORD  = 32'hFFFF_FFFF;

   typedef enum logic [0:0] {
      FUNC_READ   = 1'b0,
      FUNC_UPDATE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_OVERWRITE = 2'd1,
      ACT_NEXT      = 2'd2,
      ACT_ERASE     = 2'd3
   } action_type;

   typedef struct packed {
      func_type          func;
      logic [WORD_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] current_value;
      action_type        action;
      logic [POS_W-1:0]  write_position;
      logic              page_erased;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic erase;
   } page_cmd_type;

endpackage

// ===== design/fswl_page.sv =====
module fswl_page
   import fswl_pkg::*;
#(
   parameter int unsigned WORDS_PER_PAGE = WORDS_PER_PAGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  page_cmd_type                      cmd,
   input  logic [$clog2(WORDS_PER_PAGE)-1:0] wr_addr,
   input  logic [WORD_W-1:0]                 wr_data,
   input  logic [$clog2(WORDS_PER_PAGE)-1:0] rd_addr,
   output logic [WORD_W-1:0]                 rd_data,
   output logic                              rd_erased
);

   localparam int unsigned CW = $clog2(WORDS_PER_PAGE + 1);

   logic [WORD_W-1:0] page_mem_ff [WORDS_PER_PAGE];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_stale_ff;
   logic [CW-1:0]     fill_ff;
   logic [CW-1:0]     fill_in;

   // Words at or above the fill count have never been written since the last
   // erase, so they read as erased whatever the array holds.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.erase) begin
         fill_in = CW'(1);
      end else if (cmd.wr_en && (CW'(wr_addr) >= fill_ff)) begin
         fill_in = CW'(wr_addr) + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         page_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= page_mem_ff[rd_addr];
      rd_stale_ff <= (CW'(rd_addr) >= fill_ff);
   end

   assign rd_data   = rd_data_ff;
   assign rd_erased = rd_stale_ff || (rd_data_ff == ERASED_WORD);

endmodule

// ===== design/fswl_seq.sv =====
module fswl_seq
   import fswl_pkg::*;
#(
   parameter int unsigned WORDS_PER_PAGE = WORDS_PER_PAGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  req_type                           req_payload,
   output logic                              rsp_strobe,
   output rsp_type                           rsp_payload,
   output page_cmd_type                      cmd,
   output logic [$clog2(WORDS_PER_PAGE)-1:0] wr_addr,
   output logic [WORD_W-1:0]                 wr_data,
   output logic [$clog2(WORDS_PER_PAGE)-1:0] rd_addr,
   input  logic [WORD_W-1:0]                 rd_data,
   input  logic                              rd_erased
);

   localparam int unsigned AW = $clog2(WORDS_PER_PAGE);
   localparam int unsigned CW = $clog2(WORDS_PER_PAGE + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   logic              full;
   action_type        act;
   logic [AW-1:0]     target;
   logic              erase;
   logic [WORD_W-1:0] cur_out;

   assign full = (idx_ff == CW'(WORDS_PER_PAGE));

   always_comb begin
      act    = ACT_NONE;
      target = '0;
      erase  = 1'b0;
      if ((req_ff.func == FUNC_UPDATE) && (req_ff.new_value != prev_ff)) begin
         if (idx_ff == '0) begin
            act = ACT_NEXT;
         end else if (!full && ((~prev_ff & req_ff.new_value) == '0)) begin
            act    = ACT_OVERWRITE;
            target = AW'(idx_ff - CW'(1));
         end else begin
            act    = ACT_NEXT;
            target = AW'(idx_ff);
         end
         if (idx_ff >= CW'(WORDS_PER_PAGE - 1)) begin
            act    = ACT_ERASE;
            target = '0;
            erase  = 1'b1;
         end
      end
   end

   // An all-ones word written to a fresh slot leaves it erased, so the state
   // stays at the previous word.
   always_comb begin
      if ((act == ACT_NONE) || ((act == ACT_NEXT) && (req_ff.new_value == ERASED_WORD))) begin
         cur_out = prev_ff;
      end else begin
         cur_out = req_ff.new_value;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      prev_in   = prev_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               prev_in  = ERASED_WORD;
               req_in   = req_payload;
            end
         end
         ST_SCAN: begin
            if (full || rd_erased) begin
               state_in = ST_DECIDE;
            end else begin
               prev_in = rd_data;
               idx_in  = idx_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            state_in                = ST_IDLE;
            strobe_in               = 1'b1;
            rsp_in.current_value    = cur_out;
            rsp_in.action           = act;
            rsp_in.write_position   = POS_W'(target);
            rsp_in.page_erased      = erase;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

   assign rd_addr   = (state_ff == ST_SCAN) ? AW'(idx_ff + CW'(1)) : '0;
   assign cmd.wr_en = (state_ff == ST_DECIDE) && (act != ACT_NONE);
   assign cmd.erase = (state_ff == ST_DECIDE) && erase;
   assign wr_addr   = target;
   assign wr_data   = req_ff.new_value;

endmodule

// ===== design/flash_state_log_wear_leveler_top.sv =====
// Channel   Ports                       Transfer
// request   start, busy, req_payload    rising edge with start high and busy low
// response  rsp_strobe, rsp_payload     one cycle with rsp_strobe high, no stall
//
// An item scans the page one word per cycle from slot 0 up to the first erased
// word, so the time it takes grows with the position of that word, as set by the
// single read port of the page memory.
// A page erase only sets the fill count to one; slot 0 is written in the same cycle.
// Reset clears the fill count, so the page reads as erased at once.
// The result strobe rises at the edge where busy falls; the receiver cannot stall it.
module flash_state_log_wear_leveler_top
   import fswl_pkg::*;
#(
   parameter int unsigned WORDS_PER_PAGE = WORDS_PER_PAGE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int unsigned AW = $clog2(WORDS_PER_PAGE);

   page_cmd_type      cmd;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              rd_erased;

   fswl_seq #(
      .WORDS_PER_PAGE(WORDS_PER_PAGE)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rd_erased   (rd_erased)
   );

   fswl_page #(
      .WORDS_PER_PAGE(WORDS_PER_PAGE)
   ) u_page (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rd_erased (rd_erased)
   );

endmodule

// ===== design/fswl_checker.sv =====
module fswl_checker
   import fswl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not make the block busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("block went idle without a response");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && !$past(rsp_strobe))
      else $error("response while busy or repeated");

   a_erase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.page_erased == (rsp_payload.action == ACT_ERASE)))
      else $error("page erase flag disagrees with action");

   a_none_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_payload.action == ACT_NONE || rsp_payload.action == ACT_ERASE)
      |-> (rsp_payload.write_position == '0))
      else $error("nonzero write position without a slot write");

endmodule

bind flash_state_log_wear_leveler_top fswl_checker u_fswl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

// ===== verif/fswl_log_scoreboard.sv =====
module fswl_log_scoreboard
   import fswl_pkg::*;
#(
   parameter int unsigned PAGE_WORDS = WORDS_PER_PAGE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      pending_count
);

   logic [WORD_W-1:0] page_shadow [PAGE_WORDS];
   rsp_type           log_outcome_q [$];

   function automatic int unsigned first_erased_slot();
      for (int unsigned i = 0; i < PAGE_WORDS; i++) begin
         if (page_shadow[i] == ERASED_WORD) begin
            return i;
         end
      end
      return PAGE_WORDS;
   endfunction

   function automatic rsp_type step_state_log(req_type item);
      int unsigned       fill;
      int unsigned       slot;
      logic [WORD_W-1:0] head;
      rsp_type           outcome;
      outcome        = '0;
      outcome.action = ACT_NONE;
      fill           = first_erased_slot();
      head           = (fill == 0) ? ERASED_WORD : page_shadow[fill-1];
      if (item.func == FUNC_UPDATE && item.new_value != head) begin
         if (fill == 0) begin
            slot           = 0;
            outcome.action = ACT_NEXT;
         end else if (fill < PAGE_WORDS && ((~head & item.new_value) == '0)) begin
            slot           = fill - 1;
            outcome.action = ACT_OVERWRITE;
         end else begin
            slot           = fill;
            outcome.action = ACT_NEXT;
         end
         if (fill + 1 >= PAGE_WORDS) begin
            foreach (page_shadow[i]) begin
               page_shadow[i] = ERASED_WORD;
            end
            slot                = 0;
            outcome.action      = ACT_ERASE;
            outcome.page_erased = 1'b1;
         end
         page_shadow[slot]      = page_shadow[slot] & item.new_value;
         outcome.write_position = POS_W'(slot);
      end
      fill                  = first_erased_slot();
      outcome.current_value = (fill == 0) ? ERASED_WORD : page_shadow[fill-1];
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (page_shadow[i]) begin
            page_shadow[i] = ERASED_WORD;
         end
         log_outcome_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (log_outcome_q.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = log_outcome_q.pop_front();
               if (rsp_payload.current_value !== want.current_value) begin
                  $error("current_value: expected %h, actual %h",
                         want.current_value, rsp_payload.current_value);
                  mismatch_count++;
               end
               if (rsp_payload.action !== want.action) begin
                  $error("action: expected %0d, actual %0d",
                         want.action, rsp_payload.action);
                  mismatch_count++;
               end
               if (rsp_payload.write_position !== want.write_position) begin
                  $error("write_position: expected %0d, actual %0d",
                         want.write_position, rsp_payload.write_position);
                  mismatch_count++;
               end
               if (rsp_payload.page_erased !== want.page_erased) begin
                  $error("page_erased: expected %b, actual %b",
                         want.page_erased, rsp_payload.page_erased);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            log_outcome_q.push_back(step_state_log(req_payload));
         end
      end
      pending_count = log_outcome_q.size();
   end

endmodule

// ===== verif/flash_state_log_wear_leveler_top_tb.sv =====
module flash_state_log_wear_leveler_top_tb;
   import fswl_pkg::*;

   localparam int unsigned PAGE_WORDS    = WORDS_PER_PAGE_DEF;
   localparam int          FILL_ITEMS    = 11;
   localparam int          RANDOM_ITEMS  = 558;
   localparam int          STALL_LIMIT   = 8 * (PAGE_WORDS + 8);

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   int                mismatch_count;
   int                pending_count;
   int                stall_cycles;
   logic [WORD_W-1:0] last_state;

   flash_state_log_wear_leveler_top #(
      .WORDS_PER_PAGE(PAGE_WORDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   fswl_log_scoreboard #(
      .PAGE_WORDS(PAGE_WORDS)
   ) u_scoreboard (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         last_state <= ERASED_WORD;
      end else if (rsp_strobe) begin
         last_state <= rsp_payload.current_value;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_transfer(input func_type f, input logic [WORD_W-1:0] value,
                                input int gap);
      req_type item;
      item.func      = f;
      item.new_value = value;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int                idle_pct;
      int                gap;
      int                pick;
      logic [WORD_W-1:0] value;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_transfer(FUNC_READ, 32'h1234_5678, 0);
      send_transfer(FUNC_UPDATE, ERASED_WORD, 0);
      send_transfer(FUNC_UPDATE, 32'hFFFF_FFFE, 0);
      send_transfer(FUNC_UPDATE, 32'hFFFF_FFF0, 0);
      send_transfer(FUNC_UPDATE, 32'hFFFF_FFF0, 0);
      send_transfer(FUNC_UPDATE, 32'h0000_000F, 0);
      send_transfer(FUNC_UPDATE, ERASED_WORD, 0);
      send_transfer(FUNC_UPDATE, 32'h0000_0000, 0);
      send_transfer(FUNC_READ, 32'h0000_0000, 0);
      send_transfer(FUNC_UPDATE, 32'h8000_0000, 0);
      for (int k = 0; k < FILL_ITEMS; k++) begin
         send_transfer(FUNC_UPDATE, k[0] ? 32'hAAAA_AAAA : 32'h5555_5555, 0);
      end
      send_transfer(FUNC_READ, ERASED_WORD, 0);
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
            wait_for_drain();
         end
         idle_pct = (n < RANDOM_ITEMS / 3) ? 19 : (n < 2 * RANDOM_ITEMS / 3) ? 64 : 0;
         gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, PAGE_WORDS + 4) : 0;
         pick = $urandom_range(99);
         if (pick < 25) begin
            send_transfer(FUNC_READ, $urandom, gap);
         end else begin
            if (pick < 35) begin
               value = last_state;
            end else if (pick < 50) begin
               value = last_state & $urandom;
            end else if (pick < 58) begin
               value = last_state & ~(32'h1 << $urandom_range(WORD_W - 1));
            end else if (pick < 63) begin
               value = ERASED_WORD;
            end else if (pick < 67) begin
               value = '0;
            end else begin
               value = $urandom;
            end
            send_transfer(FUNC_UPDATE, value, gap);
         end
      end

      wait_for_drain();
      repeat (PAGE_WORDS + 8) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/fswl_pkg.sv
design/fswl_page.sv
design/fswl_seq.sv
design/flash_state_log_wear_leveler_top.sv
design/fswl_checker.sv
verif/fswl_log_scoreboard.sv
verif/flash_state_log_wear_leveler_top_tb.sv
